[src/ote_pkg.sv]
// Shared types and constants for the ordered table with extract-minimum.
// No dependencies; every other file imports this package.
`default_nettype none

package ote_pkg;

  localparam int CAPACITY_DEF = 16;

  localparam int REG_W    = 31;
  localparam int MARK_W   = 14;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  localparam logic [MARK_W-1:0] MARK_MAX      = 14'd9999;
  localparam logic [MARK_W-1:0] MARK_SENTINEL = 14'd10000;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_APPENDED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REMOVED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [REG_W-1:0]  reg_number;
    logic [MARK_W-1:0] mark_value;
  } entry_t;

endpackage

`default_nettype wire

[src/ote_ifs.sv]
// Valid/ready channel interfaces for the request and result beats.
// Depends on ote_pkg for field widths.
`default_nettype none

interface ote_in_if import ote_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [REG_W-1:0]  reg_number;
  logic [MARK_W-1:0] mark_value;

  modport source (output valid, op, reg_number, mark_value, input ready);
  modport sink   (input valid, op, reg_number, mark_value, output ready);
endinterface

interface ote_out_if import ote_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [REG_W-1:0]    removed_reg;
  logic [MARK_W-1:0]   removed_mark;
  logic [COUNT_W-1:0]  entry_count;

  modport source (output valid, status, removed_reg, removed_mark, entry_count, input ready);
  modport sink   (input valid, status, removed_reg, removed_mark, entry_count, output ready);
endinterface

`default_nettype wire

[src/ote_store.sv]
// Record store: one write port, one read port with registered read data.
// Depends on ote_pkg for the record type.
`default_nettype none

module ote_store import ote_pkg::*; #(
  parameter int DEPTH = CAPACITY_DEF,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

[src/ordered_table_extract_minimum_top.sv]
// Ordered table with extract-minimum: top level with the scan/shift sequencer.
// Depends on ote_pkg, ote_in_if/ote_out_if and ote_store.
//
// Usage:
//   in_ch carries one request per beat: op 0 appends {reg_number, mark_value}
//   at the tail (marks above 9999 are clamped), op 1 removes the oldest record
//   holding the lowest mark. out_ch returns exactly one result beat per request:
//   status, the removed record (zero unless removed) and the count afterwards.
//   Removing from an empty table reports empty; appending to a full table drops
//   the record and reports full.
//   The block works on one request at a time; in_ch.ready is high only when idle.
//   Append: the finish step loads the result and returns the sequencer to idle.
//   Remove: a scan of the n held records through the store's single read port,
//   then a gap-closing shift of the records after the hit, then the finish
//   step loads the result.
//   A result waits in the output register while out_ch.ready is low; the
//   sequencer holds in its finish step until the register frees up.
//   Reset (rst_n low, synchronous) empties the table and drops any pending
//   result; store contents are not cleared.
`default_nettype none

module ordered_table_extract_minimum_top import ote_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  ote_in_if.sink    in_ch,
  ote_out_if.source out_ch
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic                q_vld_r, q_vld_nxt;
  logic [AW-1:0]       q_idx_r, q_idx_nxt;
  logic [AW-1:0]       pos_r, pos_nxt;
  logic [MARK_W-1:0]   best_mark_r, best_mark_nxt;
  logic [REG_W-1:0]    best_reg_r, best_reg_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;

  logic                out_valid_r;
  logic [STATUS_W-1:0] out_status_r;
  logic [REG_W-1:0]    out_reg_r;
  logic [MARK_W-1:0]   out_mark_r;
  logic [COUNT_W-1:0]  out_count_r;

  logic              accept;
  logic              issue;
  logic              out_free;
  logic [MARK_W-1:0] mark_sat;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign issue       = (idx_r < count_r);
  assign out_free    = !out_valid_r || out_ch.ready;
  assign mark_sat    = (in_ch.mark_value > MARK_MAX) ? MARK_MAX : in_ch.mark_value;

  // Store write: tail append on accept, or move an entry down one slot while shifting.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_r[AW-1:0];
    wr_data = '{reg_number: in_ch.reg_number, mark_value: mark_sat};
    if (accept && in_ch.op == OP_APPEND && count_r < CAP_CNT) begin
      wr_en = 1'b1;
    end else if (state_r == S_SHIFT && q_vld_r) begin
      wr_en   = 1'b1;
      wr_addr = q_idx_r - 1'b1;
      wr_data = rd_data;
    end
  end

  ote_store #(.DEPTH(CAPACITY)) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    q_vld_nxt      = 1'b0;
    q_idx_nxt      = q_idx_r;
    pos_nxt        = pos_r;
    best_mark_nxt  = best_mark_r;
    best_reg_nxt   = best_reg_r;
    res_status_nxt = res_status_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          best_mark_nxt = '0;
          best_reg_nxt  = '0;
          state_nxt     = S_FIN;
          if (in_ch.op == OP_APPEND) begin
            if (count_r < CAP_CNT) begin
              count_nxt      = count_r + 1'b1;
              res_status_nxt = ST_APPENDED;
            end else begin
              res_status_nxt = ST_FULL;
            end
          end else if (count_r == '0) begin
            res_status_nxt = ST_EMPTY;
          end else begin
            res_status_nxt = ST_REMOVED;
            best_mark_nxt  = MARK_SENTINEL;
            pos_nxt        = '0;
            idx_nxt        = '0;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          idx_nxt   = idx_r + 1'b1;
          q_vld_nxt = 1'b1;
          q_idx_nxt = idx_r[AW-1:0];
        end
        // strict less-than keeps the oldest record on a tie
        if (q_vld_r && rd_data.mark_value < best_mark_r) begin
          best_mark_nxt = rd_data.mark_value;
          best_reg_nxt  = rd_data.reg_number;
          pos_nxt       = q_idx_r;
        end
        if (!issue && !q_vld_r) begin
          idx_nxt   = CW'(pos_r) + 1'b1;
          state_nxt = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (issue) begin
          idx_nxt   = idx_r + 1'b1;
          q_vld_nxt = 1'b1;
          q_idx_nxt = idx_r[AW-1:0];
        end
        if (!issue && !q_vld_r) begin
          count_nxt = count_r - 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      q_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      q_vld_r <= q_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_idx_r      <= q_idx_nxt;
    pos_r        <= pos_nxt;
    best_mark_r  <= best_mark_nxt;
    best_reg_r   <= best_reg_nxt;
    res_status_r <= res_status_nxt;
  end

  // Output register: load from the finish step, hold while the sink stalls.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_FIN && out_free) begin
      out_status_r <= res_status_r;
      out_reg_r    <= best_reg_r;
      out_mark_r   <= best_mark_r;
      out_count_r  <= COUNT_W'(count_r);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.removed_reg  = out_reg_r;
  assign out_ch.removed_mark = out_mark_r;
  assign out_ch.entry_count  = out_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("record count above capacity");

  a_remove_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_ch.op == OP_REMOVE && count_r != '0 |=> state_r == S_SCAN)
    else $error("remove on non-empty table did not start a scan");

  a_shift_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT && state_nxt == S_FIN |=> count_r == $past(count_r) - 1'b1)
    else $error("shift finished without dropping one record");

  a_found_record: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && res_status_r == ST_REMOVED |-> best_mark_r < MARK_SENTINEL)
    else $error("remove finished without a held record");

  a_shift_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT && wr_en |-> CW'(wr_addr) + 1'b1 < count_r)
    else $error("shift wrote outside the held records");

endmodule

`default_nettype wire
